### rtl/aarm_pkg.sv
package aarm_pkg;

    typedef struct packed {
        logic signed [31:0] angle_deg;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic               zero_axis;
    } rsp_t;

    localparam int TRIG_ITERATIONS = 24;
    localparam int CORDIC_STAGES   = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;

    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 31;
    localparam int REDUCE_STAGES = 6;

    localparam int AXIS_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int ANGLE_LAT  = REDUCE_STAGES + 1 + CORDIC_STAGES + 1;
    localparam int MATRIX_LAT = 3;
    localparam int AXIS_DLY   = (ANGLE_LAT > AXIS_LAT) ? ANGLE_LAT - AXIS_LAT : 0;
    localparam int ANGLE_DLY  = (AXIS_LAT > ANGLE_LAT) ? AXIS_LAT - ANGLE_LAT : 0;
    localparam int TOTAL_LAT  = AXIS_LAT + AXIS_DLY + MATRIX_LAT;

    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [32:0]        MOD_OFFSET  = 33'd2170552320;
    localparam logic [5:0]         SECTOR_DEG  = 6'd45;
    localparam logic [14:0]        RECIP_HI    = 15'd23302;
    localparam logic [25:0]        RECIP_TURN  = 26'd47721859;
    localparam logic [19:0]        RECIP_FRAC  = 20'd745655;
    localparam logic [12:0]        FRAC_BIAS   = 13'd22;

    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

### rtl/aarm_axis_norm.sv
module aarm_axis_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    output logic               out_valid,
    output logic signed [31:0] ux,
    output logic signed [31:0] uy,
    output logic signed [31:0] uz,
    output logic               zero
);

    localparam int SQ = aarm_pkg::SQRT_STEPS;
    localparam int DV = aarm_pkg::DIV_STEPS;

    logic signed [31:0] a_in [0:2];
    logic [31:0] mag1_reg [0:2];
    logic [2:0]  neg1_reg;
    logic        v1_reg;

    logic [31:0] mag2_reg [0:2];
    logic [2:0]  neg2_reg;
    logic [4:0]  sh2_reg;
    logic        zero2_reg;
    logic        v2_reg;
    logic [31:0] or_mag;
    logic [4:0]  msb_pos;
    logic [4:0]  sh_next;

    logic [31:0] mag3_reg [0:2];
    logic [2:0]  neg3_reg;
    logic        zero3_reg;
    logic        v3_reg;

    logic [31:0] mag4_reg [0:2];
    logic [63:0] sq4_reg [0:2];
    logic [2:0]  neg4_reg;
    logic        zero4_reg;
    logic        v4_reg;

    logic [63:0] s_rem [0:SQ];
    logic [31:0] s_root [0:SQ];
    logic [95:0] s_mag [0:SQ];
    logic [2:0]  s_neg [0:SQ];
    logic [SQ:0] s_zero;
    logic [SQ:0] s_v;

    logic [61:0] d_rem [0:DV][0:2];
    logic [30:0] d_q [0:DV][0:2];
    logic [31:0] d_len [0:DV];
    logic [2:0]  d_neg [0:DV];
    logic [DV:0] d_zero;
    logic [DV:0] d_v;

    logic signed [31:0] u_reg [0:2];
    logic               zero_reg;
    logic               v_reg;

    assign a_in[0] = ax;
    assign a_in[1] = ay;
    assign a_in[2] = az;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            mag1_reg[j] <= a_in[j][31] ? (~a_in[j] + 32'd1) : a_in[j];
            neg1_reg[j] <= a_in[j][31];
        end
    end

    always_comb
    begin
        or_mag  = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        msb_pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (or_mag[i])
            begin
                msb_pos = 5'(i);
            end
        end
        sh_next = (msb_pos >= 5'd29) ? 5'd0 : 5'd29 - msb_pos;
    end

    always_ff @(posedge clk)
    begin
        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        sh2_reg   <= sh_next;
        zero2_reg <= (or_mag == 32'd0);
        for (int j = 0; j < 3; j++)
        begin
            mag3_reg[j] <= mag2_reg[j] << sh2_reg;
            mag4_reg[j] <= mag3_reg[j];
            sq4_reg[j]  <= mag3_reg[j] * mag3_reg[j];
        end
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;
        s_rem[0]  <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
        s_root[0] <= 32'd0;
        s_mag[0]  <= {mag4_reg[0], mag4_reg[1], mag4_reg[2]};
        s_neg[0]  <= neg4_reg;
        s_zero[0] <= zero4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            s_v[0] <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            s_v[0] <= v4_reg;
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        localparam int BIT = SQ - 1 - k;
        logic [65:0] trial;
        logic        take;
        assign trial = ({34'd0, s_root[k]} << (BIT + 1)) + (66'd1 << (2 * BIT));
        assign take  = ({2'd0, s_rem[k]} >= trial);
        always_ff @(posedge clk)
        begin
            s_rem[k+1]  <= take ? 64'({2'd0, s_rem[k]} - trial) : s_rem[k];
            s_root[k+1] <= take ? (s_root[k] | (32'd1 << BIT)) : s_root[k];
            s_mag[k+1]  <= s_mag[k];
            s_neg[k+1]  <= s_neg[k];
            s_zero[k+1] <= s_zero[k];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_v[k+1] <= 1'b0;
            end
            else
            begin
                s_v[k+1] <= s_v[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            d_rem[0][j] <= {s_mag[SQ][95-32*j -: 32], 30'd0} + 62'(s_root[SQ] >> 1);
            d_q[0][j]   <= 31'd0;
        end
        d_len[0]  <= s_root[SQ];
        d_neg[0]  <= s_neg[SQ];
        d_zero[0] <= s_zero[SQ];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v[0] <= 1'b0;
        end
        else
        begin
            d_v[0] <= s_v[SQ];
        end
    end

    for (genvar k = 0; k < DV; k++)
    begin : g_div
        localparam int BIT = DV - 1 - k;
        logic [62:0] dsr;
        assign dsr = {31'd0, d_len[k]} << BIT;
        always_ff @(posedge clk)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ({1'b0, d_rem[k][j]} >= dsr)
                begin
                    d_rem[k+1][j] <= 62'({1'b0, d_rem[k][j]} - dsr);
                    d_q[k+1][j]   <= d_q[k][j] | (31'd1 << BIT);
                end
                else
                begin
                    d_rem[k+1][j] <= d_rem[k][j];
                    d_q[k+1][j]   <= d_q[k][j];
                end
            end
            d_len[k+1]  <= d_len[k];
            d_neg[k+1]  <= d_neg[k];
            d_zero[k+1] <= d_zero[k];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v[k+1] <= 1'b0;
            end
            else
            begin
                d_v[k+1] <= d_v[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            u_reg[j] <= d_neg[DV][j] ? -$signed({1'b0, d_q[DV][j]}) : $signed({1'b0, d_q[DV][j]});
        end
        zero_reg <= d_zero[DV];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= d_v[DV];
        end
    end

    assign ux        = u_reg[0];
    assign uy        = u_reg[1];
    assign uz        = u_reg[2];
    assign zero      = zero_reg;
    assign out_valid = v_reg;

endmodule

### rtl/aarm_sincos.sv
module aarm_sincos (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] angle_deg,
    output logic               out_valid,
    output logic signed [31:0] sn,
    output logic signed [31:0] cs
);

    localparam int CD = aarm_pkg::CORDIC_STAGES;

    logic [32:0] wrap_reg;
    logic [13:0] hi1_reg;
    logic [18:0] lo1_reg;
    logic [8:0]  hq1_reg;
    logic [24:0] r2_reg;
    logic [24:0] r3_reg;
    logic [18:0] q3_reg;
    logic [5:0]  ra4_reg;
    logic [18:0] q4_reg;
    logic [31:0] turn5_reg;
    logic [5:0]  red_v_reg;

    logic [28:0] hi_prod;
    logic [13:0] hi_rem;
    logic [50:0] turn_prod;
    logic [24:0] lo_rem;
    logic [38:0] frac_prod;

    logic signed [33:0] c_x [0:CD];
    logic signed [33:0] c_y [0:CD];
    logic signed [33:0] c_z [0:CD];
    logic [CD:0]        c_flip;
    logic [CD:0]        c_v;

    logic [31:0]        t_sum;
    logic [31:0]        t_turn;
    logic               flip;

    logic signed [31:0] sn_reg;
    logic signed [31:0] cs_reg;
    logic               v_reg;

    assign hi_prod   = 29'(wrap_reg[32:19]) * 29'(aarm_pkg::RECIP_HI);
    assign hi_rem    = hi1_reg - 14'(hq1_reg) * 14'(aarm_pkg::SECTOR_DEG);
    assign turn_prod = 51'(r2_reg) * 51'(aarm_pkg::RECIP_TURN);
    assign lo_rem    = r3_reg - 25'(q3_reg) * 25'(aarm_pkg::SECTOR_DEG);
    assign frac_prod = 39'({ra4_reg, aarm_pkg::FRAC_BIAS}) * 39'(aarm_pkg::RECIP_FRAC);

    always_ff @(posedge clk)
    begin
        wrap_reg  <= {angle_deg[31], angle_deg} + aarm_pkg::MOD_OFFSET;
        hi1_reg   <= wrap_reg[32:19];
        lo1_reg   <= wrap_reg[18:0];
        hq1_reg   <= hi_prod[28:20];
        r2_reg    <= {hi_rem[5:0], lo1_reg};
        r3_reg    <= r2_reg;
        q3_reg    <= turn_prod[49:31];
        ra4_reg   <= lo_rem[5:0];
        q4_reg    <= q3_reg;
        turn5_reg <= {q4_reg, frac_prod[37:25]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_v_reg <= '0;
        end
        else
        begin
            red_v_reg <= {red_v_reg[4:0], in_valid};
        end
    end

    assign t_sum  = turn5_reg + 32'h4000_0000;
    assign flip   = t_sum[31];
    assign t_turn = flip ? (turn5_reg ^ 32'h8000_0000) : turn5_reg;

    always_ff @(posedge clk)
    begin
        c_x[0]    <= aarm_pkg::CORDIC_GAIN;
        c_y[0]    <= 34'sd0;
        c_z[0]    <= 34'(signed'(t_turn));
        c_flip[0] <= flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v[0] <= 1'b0;
        end
        else
        begin
            c_v[0] <= red_v_reg[5];
        end
    end

    for (genvar k = 0; k < CD; k++)
    begin : g_cordic
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        assign dx = c_y[k] >>> k;
        assign dy = c_x[k] >>> k;
        assign at = $signed({2'b00, aarm_pkg::ATAN_TURNS[k]});
        always_ff @(posedge clk)
        begin
            if (!c_z[k][33])
            begin
                c_x[k+1] <= c_x[k] - dx;
                c_y[k+1] <= c_y[k] + dy;
                c_z[k+1] <= c_z[k] - at;
            end
            else
            begin
                c_x[k+1] <= c_x[k] + dx;
                c_y[k+1] <= c_y[k] - dy;
                c_z[k+1] <= c_z[k] + at;
            end
            c_flip[k+1] <= c_flip[k];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_v[k+1] <= 1'b0;
            end
            else
            begin
                c_v[k+1] <= c_v[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sn_reg <= 32'(c_flip[CD] ? -c_y[CD] : c_y[CD]);
        cs_reg <= 32'(c_flip[CD] ? -c_x[CD] : c_x[CD]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= c_v[CD];
        end
    end

    assign sn        = sn_reg;
    assign cs        = cs_reg;
    assign out_valid = v_reg;

endmodule

### rtl/aarm_matrix.sv
module aarm_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] ux,
    input  logic signed [31:0] uy,
    input  logic signed [31:0] uz,
    input  logic               zero,
    input  logic signed [31:0] sn,
    input  logic signed [31:0] cs,
    output logic               out_valid,
    output aarm_pkg::rsp_t     rsp
);

    function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        p = (68'(a) * 68'(b)) + 68'sd536870912;
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    logic signed [33:0] one34;
    logic signed [33:0] x34, y34, z34, s34, c34;

    logic signed [33:0] xx1_reg, yy1_reg, zz1_reg, xy1_reg, xz1_reg, yz1_reg;
    logic signed [33:0] xs1_reg, ys1_reg, zs1_reg, t1_reg, c1_reg;
    logic               zero1_reg;
    logic               v1_reg;

    logic signed [33:0] xyt2_reg, xzt2_reg, yzt2_reg;
    logic signed [33:0] dx2_reg, dy2_reg, dz2_reg;
    logic signed [33:0] xx2_reg, yy2_reg, zz2_reg, xs2_reg, ys2_reg, zs2_reg;
    logic               zero2_reg;
    logic               v2_reg;

    aarm_pkg::rsp_t rsp_reg;
    aarm_pkg::rsp_t rsp_next;
    logic           v3_reg;

    assign one34 = 34'(aarm_pkg::ONE_Q30);
    assign x34   = 34'(ux);
    assign y34   = 34'(uy);
    assign z34   = 34'(uz);
    assign s34   = 34'(sn);
    assign c34   = 34'(cs);

    always_ff @(posedge clk)
    begin
        xx1_reg   <= qmul(x34, x34);
        yy1_reg   <= qmul(y34, y34);
        zz1_reg   <= qmul(z34, z34);
        xy1_reg   <= qmul(x34, y34);
        xz1_reg   <= qmul(x34, z34);
        yz1_reg   <= qmul(y34, z34);
        xs1_reg   <= qmul(x34, s34);
        ys1_reg   <= qmul(y34, s34);
        zs1_reg   <= qmul(z34, s34);
        t1_reg    <= one34 - c34;
        c1_reg    <= c34;
        zero1_reg <= zero;

        xyt2_reg  <= qmul(xy1_reg, t1_reg);
        xzt2_reg  <= qmul(xz1_reg, t1_reg);
        yzt2_reg  <= qmul(yz1_reg, t1_reg);
        dx2_reg   <= qmul(c1_reg, one34 - xx1_reg);
        dy2_reg   <= qmul(c1_reg, one34 - yy1_reg);
        dz2_reg   <= qmul(c1_reg, one34 - zz1_reg);
        xx2_reg   <= xx1_reg;
        yy2_reg   <= yy1_reg;
        zz2_reg   <= zz1_reg;
        xs2_reg   <= xs1_reg;
        ys2_reg   <= ys1_reg;
        zs2_reg   <= zs1_reg;
        zero2_reg <= zero1_reg;

        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        if (zero2_reg)
        begin
            rsp_next           = '0;
            rsp_next.m00       = aarm_pkg::ONE_Q30;
            rsp_next.m11       = aarm_pkg::ONE_Q30;
            rsp_next.m22       = aarm_pkg::ONE_Q30;
            rsp_next.zero_axis = 1'b1;
        end
        else
        begin
            rsp_next.m00       = sat32(35'(xx2_reg) + 35'(dx2_reg));
            rsp_next.m01       = sat32(35'(xyt2_reg) - 35'(zs2_reg));
            rsp_next.m02       = sat32(35'(xzt2_reg) + 35'(ys2_reg));
            rsp_next.m10       = sat32(35'(xyt2_reg) + 35'(zs2_reg));
            rsp_next.m11       = sat32(35'(yy2_reg) + 35'(dy2_reg));
            rsp_next.m12       = sat32(35'(yzt2_reg) - 35'(xs2_reg));
            rsp_next.m20       = sat32(35'(xzt2_reg) - 35'(ys2_reg));
            rsp_next.m21       = sat32(35'(yzt2_reg) + 35'(xs2_reg));
            rsp_next.m22       = sat32(35'(zz2_reg) + 35'(dz2_reg));
            rsp_next.zero_axis = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign rsp       = rsp_reg;
    assign out_valid = v3_reg;

endmodule

### rtl/axis_angle_rotation_matrix_top.sv
// Axis-angle to 3x3 rotation matrix, fixed point.
// Request channel: drive request (angle in degrees, axis x/y/z, all signed
// Q16.16) and pulse start; a transaction is taken at each rising edge with
// start high and busy low. busy stays low, so a new request may enter
// every cycle.
// Result channel: done is high for one cycle with result holding the nine
// matrix entries (signed Q2.30) and zero_axis. A zero-length axis gives the
// identity matrix with zero_axis set.
// The result waits for the longer of the axis path (square root, one
// bit per stage, then the normalising divide, one bit per stage) and the
// angle path (modulo and degree scaling by reciprocal multiplication, then
// CORDIC with 24 iterations), then for the matrix products. Throughput:
// one transaction per cycle.
// Results leave in request order; the receiver cannot stall, so done is
// never held back.
// Reset: rst_n clears all in-flight valid bits; requests in flight are
// dropped and no done follows them.
module axis_angle_rotation_matrix_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  aarm_pkg::req_t request,
    output logic           done,
    output aarm_pkg::rsp_t result
);

    localparam int AD = aarm_pkg::AXIS_DLY;
    localparam int GD = aarm_pkg::ANGLE_DLY;

    logic               accept;
    logic               ax_valid;
    logic signed [31:0] ux, uy, uz;
    logic               ax_zero;
    logic               ang_valid;
    logic signed [31:0] sn, cs;

    logic               axd_valid;
    logic signed [31:0] uxd, uyd, uzd;
    logic               axd_zero;
    logic signed [31:0] snd, csd;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    aarm_axis_norm u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .ax        (request.axis_x),
        .ay        (request.axis_y),
        .az        (request.axis_z),
        .out_valid (ax_valid),
        .ux        (ux),
        .uy        (uy),
        .uz        (uz),
        .zero      (ax_zero)
    );

    aarm_sincos u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle_deg (request.angle_deg),
        .out_valid (ang_valid),
        .sn        (sn),
        .cs        (cs)
    );

    if (AD > 0)
    begin : g_axis_dly
        logic [96:0] line_reg [0:AD-1];
        logic [AD-1:0] v_reg;
        always_ff @(posedge clk)
        begin
            line_reg[0] <= {ux, uy, uz, ax_zero};
            for (int i = 1; i < AD; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= '0;
            end
            else
            begin
                v_reg <= AD'({v_reg, ax_valid});
            end
        end
        assign {uxd, uyd, uzd, axd_zero} = line_reg[AD-1];
        assign axd_valid = v_reg[AD-1];
    end
    else
    begin : g_axis_direct
        assign {uxd, uyd, uzd, axd_zero} = {ux, uy, uz, ax_zero};
        assign axd_valid = ax_valid;
    end

    if (GD > 0)
    begin : g_angle_dly
        logic [63:0] line_reg [0:GD-1];
        always_ff @(posedge clk)
        begin
            line_reg[0] <= {sn, cs};
            for (int i = 1; i < GD; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
        assign {snd, csd} = line_reg[GD-1];
    end
    else
    begin : g_angle_direct
        assign {snd, csd} = {sn, cs};
    end

    aarm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (axd_valid),
        .ux        (uxd),
        .uy        (uyd),
        .uz        (uzd),
        .zero      (axd_zero),
        .sn        (snd),
        .cs        (csd),
        .out_valid (done),
        .rsp       (result)
    );

`ifndef SYNTHESIS
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        axd_valid == (GD > 0 ? $past(ang_valid, GD) : ang_valid))
        else $error("axis and angle paths out of step");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, aarm_pkg::TOTAL_LAT))
        else $error("result without a request");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_axis) |-> (result.m00 == aarm_pkg::ONE_Q30
            && result.m11 == aarm_pkg::ONE_Q30 && result.m22 == aarm_pkg::ONE_Q30
            && result.m01 == 32'sd0 && result.m12 == 32'sd0 && result.m20 == 32'sd0))
        else $error("zero axis without identity matrix");
`endif

endmodule

### tb/tb_axis_angle_rotation_matrix_top.sv
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix_top;

    localparam int ITER_COUNT = (aarm_pkg::TRIG_ITERATIONS > 32) ? 32
                                                                 : aarm_pkg::TRIG_ITERATIONS;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint TURN_Q16 = 64'sd23592960;
    localparam longint GAIN_Q30 = 64'sd652032874;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    aarm_pkg::req_t request;
    logic done;
    aarm_pkg::rsp_t result;

    aarm_pkg::rsp_t matrix_q[$];
    int errors;
    bit steady;

    axis_angle_rotation_matrix_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always #6 clk = ~clk;

    function automatic longint rnd_q30(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint root64(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void sine_cosine(longint ang, output longint sn, output longint cs);
        longint rem;
        logic [31:0] bang;
        logic [63:0] tmp;
        bit flip;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        rem = ang % TURN_Q16;
        if (rem < 0)
            rem += TURN_Q16;
        tmp = (rem * 65536 + 180) / 360;
        bang = tmp[31:0];
        flip = bang[31] ^ bang[30];
        if (flip)
            bang[31] = ~bang[31];
        z = longint'(signed'(bang));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < ITER_COUNT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(aarm_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(aarm_pkg::ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic aarm_pkg::rsp_t rotation_matrix(aarm_pkg::req_t rq);
        aarm_pkg::rsp_t m;
        longint a[3];
        longint unsigned mag[3];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned len;
        longint u[3];
        longint q;
        longint sn;
        longint cs;
        longint t;
        longint xx;
        longint yy;
        longint zz;
        longint xyt;
        longint xzt;
        longint yzt;
        longint xs;
        longint ys;
        longint zs;
        int sh;
        a[0] = rq.axis_x;
        a[1] = rq.axis_y;
        a[2] = rq.axis_z;
        top = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (a[i] < 0) ? -a[i] : a[i];
            if (mag[i] > top)
                top = mag[i];
        end
        if (top == 0)
        begin
            m = '0;
            m.m00 = aarm_pkg::ONE_Q30;
            m.m11 = aarm_pkg::ONE_Q30;
            m.m22 = aarm_pkg::ONE_Q30;
            m.zero_axis = 1'b1;
            return m;
        end
        sh = 0;
        while ((top << sh) < (64'd1 << 29))
            sh++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] <<= sh;
            sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = (a[i] < 0) ? -q : q;
        end
        sine_cosine(longint'(rq.angle_deg), sn, cs);
        t = Q30_ONE - cs;
        xx = rnd_q30(u[0], u[0]);
        yy = rnd_q30(u[1], u[1]);
        zz = rnd_q30(u[2], u[2]);
        xyt = rnd_q30(rnd_q30(u[0], u[1]), t);
        xzt = rnd_q30(rnd_q30(u[0], u[2]), t);
        yzt = rnd_q30(rnd_q30(u[1], u[2]), t);
        xs = rnd_q30(u[0], sn);
        ys = rnd_q30(u[1], sn);
        zs = rnd_q30(u[2], sn);
        m.m00 = clamp32(xx + rnd_q30(cs, Q30_ONE - xx));
        m.m01 = clamp32(xyt - zs);
        m.m02 = clamp32(xzt + ys);
        m.m10 = clamp32(xyt + zs);
        m.m11 = clamp32(yy + rnd_q30(cs, Q30_ONE - yy));
        m.m12 = clamp32(yzt - xs);
        m.m20 = clamp32(xzt - ys);
        m.m21 = clamp32(yzt + xs);
        m.m22 = clamp32(zz + rnd_q30(cs, Q30_ONE - zz));
        m.zero_axis = 1'b0;
        return m;
    endfunction

    task automatic send_request(logic [31:0] ang, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z);
        aarm_pkg::req_t rq;
        rq.angle_deg = ang;
        rq.axis_x = x;
        rq.axis_y = y;
        rq.axis_z = z;
        while (!steady && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        matrix_q.push_back(rotation_matrix(rq));
    endtask

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255) - 128;
            2: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'(signed'($urandom_range(131072)) - 65536);
            4: return 32'd0;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(8) * 45) << 16;
            2: return 32'(signed'($urandom_range(1440)) - 720) << 16;
            default: return 32'(signed'($urandom_range(TURN_Q16 * 2)) - TURN_Q16);
        endcase
    endfunction

    task automatic test_zero_axis();
        send_request(32'h0, 32'h0, 32'h0, 32'h0);
        send_request(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_request(32'h8000_0000, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_extremes();
        send_request(32'h005A_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_request(32'h00B4_0000, 32'h0, 32'h0001_0000, 32'h0);
        send_request(32'h010E_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_request(32'h0168_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_request(32'hFFA6_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_request(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_request(32'h0087_0000, 32'h0, 32'h8000_0000, 32'h0000_0001);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= count / 3) && (i < count / 2);
            send_request(rand_angle(), rand_axis(), rand_axis(), rand_axis());
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        aarm_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (matrix_q.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = matrix_q.pop_front();
                if (result !== want)
                begin
                    $display("%0t mismatch: expected %h, actual %h", $time, want, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int guard;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        errors = 0;
        steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_axis();
        test_extremes();
        test_random(1150);
        start <= 1'b0;
        guard = 0;
        while (matrix_q.size() != 0 && guard < 10 * aarm_pkg::TOTAL_LAT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (aarm_pkg::TOTAL_LAT + 10) @(posedge clk);
        if (errors == 0 && matrix_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
